### src/mss_pkg.sv
// Shared types, codes and constants of the MIPS64 subset step core.
`timescale 1ns / 1ps
package mss_pkg;

    localparam int TLB_ENTRIES = 48;
    localparam int TLB_AW      = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

    localparam logic [31:0] ENTRY_RESET = 32'hBFC0_0000;
    localparam logic [31:0] CP0_W1      = 32'd47;
    localparam logic [31:0] CP0_W12     = 32'h7040_0004;
    localparam logic [31:0] CP0_W15     = 32'h0000_2E20;
    localparam logic [31:0] CP0_W16     = 32'h0000_0440;
    localparam logic [31:0] JMP_MASK    = 32'hF000_0000;

    localparam logic [4:0] CP0_INDEX    = 5'd0;
    localparam logic [4:0] CP0_RANDOM   = 5'd1;
    localparam logic [4:0] CP0_ENTRYLO0 = 5'd2;
    localparam logic [4:0] CP0_ENTRYLO1 = 5'd3;
    localparam logic [4:0] CP0_PAGEMASK = 5'd5;
    localparam logic [4:0] CP0_COUNT    = 5'd9;
    localparam logic [4:0] CP0_ENTRYHI  = 5'd10;
    localparam logic [4:0] CP0_STATUS   = 5'd12;
    localparam logic [4:0] CP0_PRID     = 5'd15;
    localparam logic [4:0] CP0_CONFIG   = 5'd16;
    localparam logic [4:0] REG_LINK     = 5'd31;

    // input item kinds
    localparam logic [1:0] OP_FETCH = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_STORE = 2'd2;
    localparam logic [1:0] OP_START = 2'd3;

    // bus requests
    localparam logic [2:0] REQ_NONE  = 3'd0;
    localparam logic [2:0] REQ_FETCH = 3'd1;
    localparam logic [2:0] REQ_LW    = 3'd2;
    localparam logic [2:0] REQ_LB    = 3'd3;
    localparam logic [2:0] REQ_SW    = 3'd4;
    localparam logic [2:0] REQ_SD    = 3'd5;

    // halt codes
    localparam logic [3:0] ERR_NONE    = 4'd0;
    localparam logic [3:0] ERR_FETCH   = 4'd1;
    localparam logic [3:0] ERR_SPECIAL = 4'd2;
    localparam logic [3:0] ERR_REGIMM  = 4'd3;
    localparam logic [3:0] ERR_C0SEL   = 4'd4;
    localparam logic [3:0] ERR_C0FUNCT = 4'd5;
    localparam logic [3:0] ERR_C0RS    = 4'd6;
    localparam logic [3:0] ERR_OPCODE  = 4'd7;
    localparam logic [3:0] ERR_LW      = 4'd8;
    localparam logic [3:0] ERR_LB      = 4'd9;
    localparam logic [3:0] ERR_SW      = 4'd10;
    localparam logic [3:0] ERR_SD      = 4'd11;

    // major opcodes
    localparam logic [5:0] MOP_SPECIAL = 6'h00;
    localparam logic [5:0] MOP_REGIMM  = 6'h01;
    localparam logic [5:0] MOP_J       = 6'h02;
    localparam logic [5:0] MOP_JAL     = 6'h03;
    localparam logic [5:0] MOP_BEQ     = 6'h04;
    localparam logic [5:0] MOP_BNE     = 6'h05;
    localparam logic [5:0] MOP_ADDIU   = 6'h09;
    localparam logic [5:0] MOP_SLTI    = 6'h0A;
    localparam logic [5:0] MOP_ANDI    = 6'h0C;
    localparam logic [5:0] MOP_ORI     = 6'h0D;
    localparam logic [5:0] MOP_LUI     = 6'h0F;
    localparam logic [5:0] MOP_COP0    = 6'h10;
    localparam logic [5:0] MOP_LW      = 6'h23;
    localparam logic [5:0] MOP_LBU     = 6'h24;
    localparam logic [5:0] MOP_SW      = 6'h2B;
    localparam logic [5:0] MOP_SD      = 6'h3F;

    // special functs, plus the TLBWI funct of COP0
    localparam logic [5:0] FN_SLL   = 6'h00;
    localparam logic [5:0] FN_SRL   = 6'h02;
    localparam logic [5:0] FN_SRA   = 6'h03;
    localparam logic [5:0] FN_JR    = 6'h08;
    localparam logic [5:0] FN_JALR  = 6'h09;
    localparam logic [5:0] FN_SYNC  = 6'h0F;
    localparam logic [5:0] FN_ADDU  = 6'h21;
    localparam logic [5:0] FN_AND   = 6'h24;
    localparam logic [5:0] FN_OR    = 6'h25;
    localparam logic [5:0] FN_XOR   = 6'h26;
    localparam logic [5:0] FN_NOR   = 6'h27;
    localparam logic [5:0] FN_SLT   = 6'h2A;
    localparam logic [5:0] FN_SLTU  = 6'h2B;
    localparam logic [5:0] FN_DADDU = 6'h2D;
    localparam logic [5:0] FN_TLBWI = 6'h02;

    localparam logic [4:0] C0_MF = 5'h00;
    localparam logic [4:0] C0_MT = 5'h04;
    localparam logic [4:0] C0_CO = 5'h10;

    localparam logic [4:0] RI_BLTZ = 5'd0;
    localparam logic [4:0] RI_BGEZ = 5'd1;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_FETCH = 4'b0010,
        PH_LOAD  = 4'b0100,
        PH_STORE = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [2:0]  request;
        logic [31:0] address;
        logic [63:0] write_data;
        logic        retired;
        logic        halted;
        logic [3:0]  error_code;
        logic [31:0] error_pc;
    } t_result;

    function automatic logic [31:0] cp0_reset(input logic [4:0] idx);
        logic [31:0] v;
        v = 32'd0;
        if (idx == CP0_RANDOM) v = CP0_W1;
        if (idx == CP0_STATUS) v = CP0_W12;
        if (idx == CP0_PRID)   v = CP0_W15;
        if (idx == CP0_CONFIG) v = CP0_W16;
        return v;
    endfunction

    function automatic logic [63:0] sx32(input logic [31:0] w);
        return {{32{w[31]}}, w};
    endfunction

endpackage

### src/mss_in_if.sv
// Input channel: bus responses and start commands.
`timescale 1ns / 1ps
interface mss_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] data;
    logic        fault;

    modport source (output valid, output opcode, output data, output fault, input ready);
    modport sink   (input valid, input opcode, input data, input fault, output ready);
endinterface

### src/mss_out_if.sv
// Output channel: bus requests plus core status.
`timescale 1ns / 1ps
interface mss_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  request;
    logic [31:0] address;
    logic [63:0] write_data;
    logic        retired;
    logic        halted;
    logic [3:0]  error_code;
    logic [31:0] error_pc;

    modport source (output valid, output request, output address, output write_data,
                    output retired, output halted, output error_code, output error_pc,
                    input ready);
    modport sink   (input valid, input request, input address, input write_data,
                    input retired, input halted, input error_code, input error_pc,
                    output ready);
endinterface

### src/mips64_subset_instruction_step.sv
// Top level: MIPS64 subset core stepped by bus responses.
//
//  channel   dir  handshake      payload
//  i_item    in   valid/ready    opcode[1:0] data[31:0] fault
//  o_result  out  valid/ready    request address write_data retired halted
//                                error_code error_pc
//  i_cfg_*   in   write enable   entry point [31:0]
//
// The accept edge reads rs/rt from the register file memory; the execute
// edge then executes, writes back and loads the result register. A new item
// is accepted only after the previous one has executed; the result register
// lets a new item enter while the previous result waits. Execute holds while
// the result register is full and not taken. Reset is synchronous; the
// register file uses per-entry valid bits, so there is no clearing pass.
`timescale 1ns / 1ps
module mips64_subset_instruction_step
    import mss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_wdata,
    mss_in_if.sink            i_item,
    mss_out_if.source         o_result
);

    // control state
    logic         r_s1, r_ov;
    t_phase       r_phase, n_phase;
    logic         r_halt, n_halt;
    logic [3:0]   r_code, n_code;
    logic [31:0]  r_pc, n_pc, r_npc, n_npc, r_apc, n_apc, r_entry;
    logic [31:0]  r_pend, n_pend;
    logic [63:0]  r_retcnt;
    logic [31:0]  r_cp0 [32];
    logic [31:0]  n_cp0 [32];
    logic [31:0]  r_rf_vld;

    // stage-1 item
    logic [1:0]   r_op;
    logic [31:0]  r_data;
    logic         r_fault;

    // memories
    logic [63:0]  r_rf [32];
    logic [127:0] r_tlb [TLB_ENTRIES];
    logic [63:0]  r_rs_q, r_rt_q;
    logic         r_rs_v, r_rt_v;

    t_result      r_res, n_res;
    logic         accept, exec, retire;
    logic         rf_we, tlb_we;
    logic [4:0]   rf_wa;
    logic [63:0]  rf_wd;
    logic [TLB_AW-1:0] tlb_wa;
    logic [127:0] tlb_wd;

    assign i_item.ready = !r_s1;
    assign accept       = i_item.valid && !r_s1;
    assign exec         = r_s1 && (!r_ov || o_result.ready);

    assign o_result.valid      = r_ov;
    assign o_result.request    = r_res.request;
    assign o_result.address    = r_res.address;
    assign o_result.write_data = r_res.write_data;
    assign o_result.retired    = r_res.retired;
    assign o_result.halted     = r_res.halted;
    assign o_result.error_code = r_res.error_code;
    assign o_result.error_pc   = r_res.error_pc;

    // execute
    always_comb begin
        logic [63:0] a, b, imm, link;
        logic [31:0] ins, bw, ea, bt, jt, cw;
        logic [5:0]  mop, fn, tidx;
        logic [4:0]  rs, rt, rd, sa;
        logic [3:0]  err;
        logic [2:0]  req;
        logic [63:0] wd;

        a    = r_rs_v ? r_rs_q : 64'd0;
        b    = r_rt_v ? r_rt_q : 64'd0;
        ins  = r_data;
        mop  = ins[31:26];
        fn   = ins[5:0];
        rs   = ins[25:21];
        rt   = ins[20:16];
        rd   = ins[15:11];
        sa   = ins[10:6];
        bw   = b[31:0];
        imm  = {{48{ins[15]}}, ins[15:0]};
        ea   = a[31:0] + imm[31:0];
        bt   = r_pc + 32'd4 + {imm[29:0], 2'b00};
        jt   = ((r_pc + 32'd4) & JMP_MASK) | {ins[25:0], 2'b00};
        link = {32'd0, r_pc + 32'd8};
        cw   = r_cp0[rd];
        tidx = r_cp0[CP0_INDEX][5:0];
        err  = ERR_NONE;
        req  = REQ_NONE;
        wd   = 64'd0;

        n_phase = r_phase;
        n_halt  = r_halt;
        n_code  = r_code;
        n_pc    = r_pc;
        n_npc   = r_npc;
        n_apc   = r_apc;
        n_pend  = r_pend;
        n_cp0   = r_cp0;
        rf_we   = 1'b0;
        rf_wa   = rt;
        rf_wd   = 64'd0;
        tlb_we  = 1'b0;
        tlb_wa  = tidx[TLB_AW-1:0];
        tlb_wd  = {r_cp0[CP0_ENTRYLO1], r_cp0[CP0_ENTRYLO0],
                   r_cp0[CP0_ENTRYHI], r_cp0[CP0_PAGEMASK]};
        retire  = 1'b0;
        n_res   = '0;

        if (r_op == OP_START) begin
            if (r_phase == PH_LOAD || r_phase == PH_STORE) begin
                n_npc = r_pc;
                n_pc  = r_apc;
            end
            n_halt        = 1'b0;
            n_code        = ERR_NONE;
            n_phase       = PH_FETCH;
            n_res.request = REQ_FETCH;
            n_res.address = n_pc;
        end else if (r_halt
                     || !((r_phase == PH_FETCH && r_op == OP_FETCH)
                       || (r_phase == PH_LOAD && r_op == OP_LOAD)
                       || (r_phase == PH_STORE && r_op == OP_STORE))) begin
            // ignored response
        end else if (r_phase == PH_FETCH) begin
            n_apc = r_pc;
            if (r_fault) begin
                n_halt  = 1'b1;
                n_code  = ERR_FETCH;
                n_phase = PH_IDLE;
            end else begin
                n_pend = ins;
                n_pc   = r_npc;
                n_npc  = r_npc + 32'd4;
                unique case (mop)
                    MOP_SPECIAL: begin
                        rf_wa = rd;
                        unique case (fn)
                            FN_SLL:   begin rf_we = 1'b1; rf_wd = sx32(bw << sa); end
                            FN_SRL:   begin rf_we = 1'b1; rf_wd = sx32(bw >> sa); end
                            FN_SRA:   begin
                                rf_we = 1'b1;
                                rf_wd = sx32($unsigned($signed(bw) >>> sa));
                            end
                            FN_JR:    n_npc = a[31:0];
                            FN_JALR:  begin
                                rf_we = 1'b1;
                                rf_wd = link;
                                // rs is read after the link write
                                n_npc = (rd == rs && rd != 5'd0) ? link[31:0] : a[31:0];
                            end
                            FN_SYNC:  ;
                            FN_ADDU:  begin rf_we = 1'b1; rf_wd = sx32(a[31:0] + bw); end
                            FN_AND:   begin rf_we = 1'b1; rf_wd = a & b; end
                            FN_OR:    begin rf_we = 1'b1; rf_wd = a | b; end
                            FN_XOR:   begin rf_we = 1'b1; rf_wd = a ^ b; end
                            FN_NOR:   begin rf_we = 1'b1; rf_wd = ~(a | b); end
                            FN_SLT:   begin
                                rf_we = 1'b1;
                                rf_wd = {63'd0, $signed(a) < $signed(b)};
                            end
                            FN_SLTU:  begin rf_we = 1'b1; rf_wd = {63'd0, a < b}; end
                            FN_DADDU: begin rf_we = 1'b1; rf_wd = a + b; end
                            default:  err = ERR_SPECIAL;
                        endcase
                    end
                    MOP_REGIMM: begin
                        if (rt == RI_BLTZ) begin
                            if (a[63]) n_npc = bt;
                        end else if (rt == RI_BGEZ) begin
                            if (!a[63]) n_npc = bt;
                        end else begin
                            err = ERR_REGIMM;
                        end
                    end
                    MOP_J:     n_npc = jt;
                    MOP_JAL:   begin
                        rf_we = 1'b1; rf_wa = REG_LINK; rf_wd = link; n_npc = jt;
                    end
                    MOP_BEQ:   if (a == b) n_npc = bt;
                    MOP_BNE:   if (a != b) n_npc = bt;
                    MOP_ADDIU: begin rf_we = 1'b1; rf_wd = a + imm; end
                    MOP_SLTI:  begin
                        rf_we = 1'b1;
                        rf_wd = {63'd0, $signed(a) < $signed(imm)};
                    end
                    MOP_ANDI:  begin rf_we = 1'b1; rf_wd = a & {48'd0, ins[15:0]}; end
                    MOP_ORI:   begin rf_we = 1'b1; rf_wd = a | {48'd0, ins[15:0]}; end
                    MOP_LUI:   begin rf_we = 1'b1; rf_wd = sx32({ins[15:0], 16'd0}); end
                    MOP_COP0:  begin
                        unique case (rs)
                            C0_MF: begin
                                if (ins[2:0] != 3'd0) err = ERR_C0SEL;
                                else begin rf_we = 1'b1; rf_wd = sx32(cw); end
                            end
                            C0_MT: begin
                                if (ins[2:0] != 3'd0) err = ERR_C0SEL;
                                else if (rd != CP0_PRID) n_cp0[rd] = bw;
                            end
                            C0_CO: begin
                                if (fn == FN_TLBWI) begin
                                    tlb_we = ({1'b0, tidx} < 7'(TLB_ENTRIES));
                                end else begin
                                    err = ERR_C0FUNCT;
                                end
                            end
                            default: err = ERR_C0RS;
                        endcase
                    end
                    MOP_LW:  begin req = REQ_LW; end
                    MOP_LBU: begin req = REQ_LB; end
                    MOP_SW:  begin req = REQ_SW; wd = {32'd0, bw}; end
                    MOP_SD:  begin req = REQ_SD; wd = b; end
                    default: err = ERR_OPCODE;
                endcase
                if (err != ERR_NONE) begin
                    rf_we   = 1'b0;
                    tlb_we  = 1'b0;
                    n_cp0   = r_cp0;
                    n_npc   = r_npc;
                    n_pc    = r_pc;
                    n_halt  = 1'b1;
                    n_code  = err;
                    n_phase = PH_IDLE;
                end else if (req != REQ_NONE) begin
                    n_phase          = (req == REQ_LW || req == REQ_LB) ? PH_LOAD : PH_STORE;
                    n_res.request    = req;
                    n_res.address    = ea;
                    n_res.write_data = wd;
                end else begin
                    retire = 1'b1;
                end
            end
        end else begin
            // data response for the pending load or store
            if (r_fault) begin
                n_npc   = r_pc;
                n_pc    = r_apc;
                n_halt  = 1'b1;
                n_phase = PH_IDLE;
                if (r_phase == PH_LOAD) n_code = (r_pend[31:26] == MOP_LBU) ? ERR_LB : ERR_LW;
                else n_code = (r_pend[31:26] == MOP_SW) ? ERR_SW : ERR_SD;
            end else begin
                if (r_phase == PH_LOAD) begin
                    rf_we = 1'b1;
                    rf_wa = r_pend[20:16];
                    rf_wd = (r_pend[31:26] == MOP_LBU) ? {56'd0, ins[7:0]} : sx32(ins);
                end
                retire = 1'b1;
            end
        end

        if (retire) begin
            n_cp0[CP0_COUNT] = n_cp0[CP0_COUNT] + 32'd1;
            n_phase          = PH_FETCH;
            n_res.request    = REQ_FETCH;
            n_res.address    = n_pc;
            n_res.retired    = 1'b1;
        end
        n_res.halted     = n_halt;
        n_res.error_code = n_halt ? n_code : ERR_NONE;
        n_res.error_pc   = n_halt ? n_apc : 32'd0;
        if (rf_wa == 5'd0) rf_we = 1'b0;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1     <= 1'b0;
            r_ov     <= 1'b0;
            r_phase  <= PH_IDLE;
            r_halt   <= 1'b0;
            r_code   <= ERR_NONE;
            r_entry  <= ENTRY_RESET;
            r_pc     <= ENTRY_RESET;
            r_npc    <= ENTRY_RESET + 32'd4;
            r_apc    <= 32'd0;
            r_pend   <= 32'd0;
            r_retcnt <= 64'd0;
            r_rf_vld <= 32'd0;
            for (int i = 0; i < 32; i++) r_cp0[i] <= cp0_reset(5'(i));
        end else begin
            if (accept) r_s1 <= 1'b1;
            else if (exec) r_s1 <= 1'b0;
            if (exec) r_ov <= 1'b1;
            else if (o_result.ready) r_ov <= 1'b0;
            if (exec) begin
                r_phase <= n_phase;
                r_halt  <= n_halt;
                r_code  <= n_code;
                r_pc    <= n_pc;
                r_npc   <= n_npc;
                r_apc   <= n_apc;
                r_pend  <= n_pend;
                r_cp0   <= n_cp0;
                if (retire) r_retcnt <= r_retcnt + 64'd1;
                if (rf_we) r_rf_vld[rf_wa] <= 1'b1;
            end
            if (i_cfg_we) begin
                r_entry <= i_cfg_wdata;
                if (r_phase == PH_IDLE && !r_halt) begin
                    r_pc  <= i_cfg_wdata;
                    r_npc <= i_cfg_wdata + 32'd4;
                end
            end
        end
    end

    // stage-1 payload, result register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_item.opcode;
            r_data  <= i_item.data;
            r_fault <= i_item.fault;
        end
        if (exec) r_res <= n_res;
    end

    // register file memory: two registered reads on transfer, one write
    always_ff @(posedge i_clk) begin
        if (exec && rf_we) r_rf[rf_wa] <= rf_wd;
        if (accept) begin
            r_rs_q <= r_rf[i_item.data[25:21]];
            r_rt_q <= r_rf[i_item.data[20:16]];
            r_rs_v <= r_rf_vld[i_item.data[25:21]];
            r_rt_v <= r_rf_vld[i_item.data[20:16]];
        end
    end

    // TLB memory, write only
    always_ff @(posedge i_clk) begin
        if (exec && tlb_we) r_tlb[tlb_wa] <= tlb_wd;
    end

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1 |-> !i_item.ready) else $error("ready while an item is in execute");
    a_halt_no_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_res.halted) |-> (r_res.request == REQ_NONE))
        else $error("bus request issued while halted");
    a_retire_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_res.retired) |-> (r_res.request == REQ_FETCH))
        else $error("retirement without next fetch");
    a_code_when_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_res.halted) |-> (r_res.error_code == ERR_NONE && r_res.error_pc == 32'd0))
        else $error("error status while running");
    a_accept_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1) else $error("accepted item lost");

endmodule
